/* design/rmcc_pkg.sv */
// Types, constants and helpers shared by the rook magic collision checker.
// No dependencies.
`default_nettype none

package rmcc_pkg;

    localparam int SQ_W     = 6;
    localparam int WORD_W   = 64;
    localparam int BITS_W   = 4;
    localparam int MAX_BITS = 12;
    localparam int STEP_W   = 12;
    localparam int TERM_W   = 4;
    localparam int EPOCH_W  = 4;

    localparam logic [WORD_W-1:0] FILE_A_BITS = 64'h0101010101010101;
    localparam logic [WORD_W-1:0] FILE_H_BITS = 64'h8080808080808080;
    localparam logic [WORD_W-1:0] RANK_1_BITS = 64'h00000000000000FF;
    localparam logic [WORD_W-1:0] RANK_8_BITS = 64'hFF00000000000000;
    localparam logic [BITS_W-1:0] FULL_MASK_BITS = 4'd14;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 4'd15;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic start;
        logic run;
    } step_ctrl_t;

    typedef struct packed {
        logic scan_done;
        logic last;
    } step_stat_t;

    typedef struct packed {
        logic issue;
        logic clear;
    } seen_ctrl_t;

    // trailing zero count of a 12-bit value; zero input gives 0
    function automatic logic [TERM_W-1:0] ctz12(input logic [STEP_W-1:0] v);
        logic [TERM_W-1:0] r;
        r = '0;
        for (int i = STEP_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = TERM_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/rmcc_if.sv */
// Handshake channels for the collision checker: item in, result out.
// Depends on rmcc_pkg.
`default_nettype none

interface rmcc_item_if
    import rmcc_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [SQ_W-1:0]   square;
    logic [WORD_W-1:0] candidate;

    modport source (output valid, output square, output candidate, input ready);
    modport sink   (input valid, input square, input candidate, output ready);
endinterface

interface rmcc_result_if
    import rmcc_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic              accepted;
    logic [BITS_W-1:0] index_bits;
    logic [WORD_W-1:0] relevant_mask;

    modport source (output valid, output accepted, output index_bits, output relevant_mask,
                    input ready);
    modport sink   (input valid, input accepted, input index_bits, input relevant_mask,
                    output ready);
endinterface

`default_nettype wire

/* design/rook_magic_collision_check.sv */
// Rook magic candidate check. After scanning the mask, each item walks every mask
// subset, one subset per cycle via the Gray-code adder and one map read/write per
// cycle. A collision ends the walk early; a zero candidate skips it. Reset is
// asynchronous; after reset and after every 15th item a clearing pass over all
// SEEN_DEPTH map entries runs with ready low. Results sit in an output register.
`default_nettype none

module rook_magic_collision_check
    import rmcc_pkg::*;
#(
    parameter int SEEN_DEPTH = 4096
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    rmcc_item_if.sink       item,
    rmcc_result_if.source   result
);

    localparam int ADDR_W = $clog2(SEEN_DEPTH);

    state_t             state_reg;
    state_t             state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [WORD_W-1:0]  mask_reg;
    logic [BITS_W-1:0]  bits_reg;
    logic               fail_reg;

    logic               res_valid_reg;
    logic               res_accepted_reg;
    logic [BITS_W-1:0]  res_bits_reg;
    logic [WORD_W-1:0]  res_mask_reg;

    logic [WORD_W-1:0]   mask_w;
    logic [BITS_W-1:0]   bits_w;
    step_ctrl_t          step_ctrl;
    step_stat_t          step_stat;
    seen_ctrl_t          seen_ctrl;
    logic [MAX_BITS-1:0] idx_w;
    logic                hit_w;
    logic                take;
    logic                load_res;
    logic                clr_last;

    rmcc_mask u_mask (
        .square (item.square),
        .mask   (mask_w),
        .bits   (bits_w)
    );

    rmcc_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (step_ctrl),
        .candidate (item.candidate),
        .mask      (mask_w),
        .bits      (bits_reg),
        .stat      (step_stat),
        .idx       (idx_w)
    );

    rmcc_seen #(
        .SEEN_DEPTH (SEEN_DEPTH)
    ) u_seen (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (seen_ctrl),
        .issue_addr (ADDR_W'(idx_w)),
        .clear_addr (clr_cnt_reg),
        .epoch      (epoch_reg),
        .hit        (hit_w)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step_stat.scan_done)
                begin
                    state_next = fail_reg ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (hit_w)
                begin
                    state_next = ST_DONE;
                end
                else if (step_stat.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    state_next = (epoch_reg == EPOCH_LAST) ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        item.ready      = (state_reg == ST_IDLE);
        take            = item.valid && item.ready;
        clr_last        = (clr_cnt_reg == ADDR_W'(SEEN_DEPTH - 1));
        load_res        = (state_reg == ST_DONE) && (!res_valid_reg || result.ready);
        step_ctrl.load  = take;
        step_ctrl.scan  = (state_reg == ST_SCAN) && !step_stat.scan_done;
        step_ctrl.start = (state_reg == ST_SCAN) && step_stat.scan_done;
        step_ctrl.run   = (state_reg == ST_RUN) && !step_stat.last;
        seen_ctrl.issue = (state_reg == ST_RUN) && !hit_w;
        seen_ctrl.clear = (state_reg == ST_CLEAR);
        result.valid         = res_valid_reg;
        result.accepted      = res_accepted_reg;
        result.index_bits    = res_bits_reg;
        result.relevant_mask = res_mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            epoch_reg     <= EPOCH_FIRST;
            fail_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (take)
            begin
                fail_reg <= (item.candidate == '0);
            end
            else if (((state_reg == ST_RUN) || (state_reg == ST_DRAIN)) && hit_w)
            begin
                fail_reg <= 1'b1;
            end
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
                epoch_reg     <= (epoch_reg == EPOCH_LAST) ? EPOCH_FIRST
                                                           : epoch_reg + EPOCH_W'(1);
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mask_reg <= mask_w;
            bits_reg <= bits_w;
        end
        if (load_res)
        begin
            res_accepted_reg <= !fail_reg;
            res_bits_reg     <= bits_reg;
            res_mask_reg     <= mask_reg;
        end
    end

endmodule

`default_nettype wire

/* design/rmcc_mask.sv */
// Rook relevant-occupancy mask and its bit count for one square.
// Depends on rmcc_pkg.
`default_nettype none

module rmcc_mask
    import rmcc_pkg::*;
(
    input  wire logic [SQ_W-1:0]   square,
    output logic      [WORD_W-1:0] mask,
    output logic      [BITS_W-1:0] bits
);

    logic [2:0]        rank;
    logic [2:0]        file;
    logic [WORD_W-1:0] here;
    logic [WORD_W-1:0] edges;
    logic [WORD_W-1:0] line;
    logic [BITS_W-1:0] removed;

    always_comb
    begin
        rank    = square[5:3];
        file    = square[2:0];
        here    = WORD_W'(1) << square;
        edges   = '0;
        removed = '0;
        if (file != 3'd0)
        begin
            edges   = edges | FILE_A_BITS;
            removed = removed + 4'd1;
        end
        if (file != 3'd7)
        begin
            edges   = edges | FILE_H_BITS;
            removed = removed + 4'd1;
        end
        if (rank != 3'd0)
        begin
            edges   = edges | RANK_1_BITS;
            removed = removed + 4'd1;
        end
        if (rank != 3'd7)
        begin
            edges   = edges | RANK_8_BITS;
            removed = removed + 4'd1;
        end
        line = (RANK_1_BITS << {rank, 3'b000}) | (FILE_A_BITS << file);
        mask = line & ~edges & ~here;
        bits = FULL_MASK_BITS - removed;
    end

endmodule

`default_nettype wire

/* design/rmcc_step.sv */
// Subset product unit: walks mask subsets in Gray-code order, so each step is
// one 64-bit add or subtract of a shifted candidate. Depends on rmcc_pkg.
`default_nettype none

module rmcc_step
    import rmcc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire step_ctrl_t          ctrl,
    input  wire logic [WORD_W-1:0]   candidate,
    input  wire logic [WORD_W-1:0]   mask,
    input  wire logic [BITS_W-1:0]   bits,
    output step_stat_t               stat,
    output logic      [MAX_BITS-1:0] idx
);

    logic [WORD_W-1:0] term_reg [MAX_BITS];
    logic [TERM_W-1:0] fill_reg;
    logic [WORD_W-1:0] cand_sh_reg;
    logic [WORD_W-1:0] mask_sh_reg;
    logic [STEP_W-1:0] step_reg;
    logic [WORD_W-1:0] product_reg;
    logic [WORD_W-1:0] add_reg;
    logic              neg_reg;

    logic [STEP_W:0]   nxt_flip;
    logic [TERM_W-1:0] flip_pos;
    logic [TERM_W-1:0] flip_pos1;
    logic [STEP_W-1:0] last_step;
    logic [MAX_BITS-1:0] prod_top;

    // flip for step k+1 -> k+2: bit ctz(k+2); it is set afterwards when bit above is 0
    always_comb
    begin
        nxt_flip  = {1'b0, step_reg} + (STEP_W+1)'(2);
        flip_pos  = ctz12(nxt_flip[STEP_W-1:0]);
        flip_pos1 = flip_pos + TERM_W'(1);
        last_step = STEP_W'(((STEP_W+1)'(1) << bits) - (STEP_W+1)'(1));
        prod_top  = product_reg[WORD_W-1 -: MAX_BITS];
        idx       = prod_top >> (BITS_W'(MAX_BITS) - bits);
        stat.scan_done = (mask_sh_reg == '0);
        stat.last      = (step_reg == last_step);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cand_sh_reg <= candidate;
            mask_sh_reg <= mask;
        end
        else if (ctrl.scan)
        begin
            if (mask_sh_reg[0])
            begin
                term_reg[fill_reg[TERM_W-1:0]] <= cand_sh_reg;
            end
            cand_sh_reg <= cand_sh_reg << 1;
            mask_sh_reg <= mask_sh_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            step_reg <= '0;
        end
        else if (ctrl.load)
        begin
            fill_reg <= '0;
        end
        else if (ctrl.scan)
        begin
            if (mask_sh_reg[0])
            begin
                fill_reg <= fill_reg + TERM_W'(1);
            end
        end
        else if (ctrl.start)
        begin
            step_reg <= '0;
        end
        else if (ctrl.run)
        begin
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            product_reg <= '0;
            add_reg     <= term_reg[0];
            neg_reg     <= 1'b0;
        end
        else if (ctrl.run)
        begin
            product_reg <= neg_reg ? (product_reg - add_reg) : (product_reg + add_reg);
            add_reg     <= term_reg[flip_pos];
            neg_reg     <= nxt_flip[flip_pos1];
        end
    end

endmodule

`default_nettype wire

/* design/rmcc_seen.sv */
// Seen-index map: epoch-tagged memory with a read-check-write pipeline and a
// bypass for back-to-back equal indices. Depends on rmcc_pkg.
`default_nettype none

module rmcc_seen
    import rmcc_pkg::*;
#(
    parameter int SEEN_DEPTH = 4096
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire seen_ctrl_t                    ctrl,
    input  wire logic [$clog2(SEEN_DEPTH)-1:0] issue_addr,
    input  wire logic [$clog2(SEEN_DEPTH)-1:0] clear_addr,
    input  wire logic [EPOCH_W-1:0]            epoch,
    output logic                               hit
);

    localparam int ADDR_W = $clog2(SEEN_DEPTH);

    logic [EPOCH_W-1:0] mem [SEEN_DEPTH];
    logic [EPOCH_W-1:0] rd_data_reg;
    logic               chk_valid_reg;
    logic [ADDR_W-1:0]  chk_addr_reg;
    logic               prev_valid_reg;
    logic [ADDR_W-1:0]  prev_addr_reg;

    // read happens before the write of the same edge, hence the bypass compare
    always_comb
    begin
        hit = chk_valid_reg &&
              ((rd_data_reg == epoch) || (prev_valid_reg && (prev_addr_reg == chk_addr_reg)));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            rd_data_reg <= mem[issue_addr];
        end
        if (ctrl.clear)
        begin
            mem[clear_addr] <= '0;
        end
        else if (chk_valid_reg)
        begin
            mem[chk_addr_reg] <= epoch;
        end
        chk_addr_reg  <= issue_addr;
        prev_addr_reg <= chk_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg  <= 1'b0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            chk_valid_reg  <= ctrl.issue;
            prev_valid_reg <= chk_valid_reg;
        end
    end

endmodule

`default_nettype wire

/* verif/rook_magic_collision_check_tb.sv */
// Testbench for rook_magic_collision_check: offers square/candidate beats, predicts
// each verdict with a behavioral model of the subset walk and checks every result beat.
// Depends on rmcc_pkg, the rmcc_if interfaces and the DUT.

module rook_magic_collision_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmcc_pkg::*;

    localparam int SEEN_DEPTH   = 4096;
    localparam int RANDOM_ITEMS = 122;
    localparam int MAGIC_COUNT  = 10;
    localparam int HOLD_CYCLES  = 20000;

    typedef struct {
        logic              accepted;
        logic [BITS_W-1:0] index_bits;
        logic [WORD_W-1:0] relevant_mask;
    } verdict_t;

    class magic_verdict_book;
        verdict_t pending_verdicts[$];
        int       mismatch_count;
        bit       seen_index[SEEN_DEPTH];

        function new();
            mismatch_count = 0;
        endfunction

        function verdict_t predict_verdict(logic [SQ_W-1:0] sq, logic [WORD_W-1:0] cand);
            verdict_t          v;
            logic [WORD_W-1:0] here;
            logic [WORD_W-1:0] edges;
            logic [WORD_W-1:0] subset;
            logic [WORD_W-1:0] slot;
            int                shift;
            here = 64'd1 << sq;
            edges = '0;
            v.index_bits = FULL_MASK_BITS;
            // an edge only drops out of the mask when the square is not on it
            if ((here & FILE_A_BITS) == 0)
            begin
                edges |= FILE_A_BITS;
                v.index_bits = v.index_bits - 1'b1;
            end
            if ((here & FILE_H_BITS) == 0)
            begin
                edges |= FILE_H_BITS;
                v.index_bits = v.index_bits - 1'b1;
            end
            if ((here & RANK_1_BITS) == 0)
            begin
                edges |= RANK_1_BITS;
                v.index_bits = v.index_bits - 1'b1;
            end
            if ((here & RANK_8_BITS) == 0)
            begin
                edges |= RANK_8_BITS;
                v.index_bits = v.index_bits - 1'b1;
            end
            v.relevant_mask = ((RANK_1_BITS << (8 * sq[5:3])) | (FILE_A_BITS << sq[2:0]))
                              & ~edges & ~here;
            shift = WORD_W - int'(v.index_bits);
            v.accepted = (cand != '0);
            foreach (seen_index[i])
                seen_index[i] = 1'b0;
            subset = '0;
            if (v.accepted)
            begin
                // carry-rippler walk over every subset of the mask, empty set first
                do
                begin
                    slot = (subset * cand) >> shift;
                    if (slot >= SEEN_DEPTH || seen_index[slot[11:0]])
                    begin
                        v.accepted = 1'b0;
                        break;
                    end
                    seen_index[slot[11:0]] = 1'b1;
                    subset = (subset - v.relevant_mask) & v.relevant_mask;
                end
                while (subset != '0);
            end
            return v;
        endfunction

        function void note_candidate(logic [SQ_W-1:0] sq, logic [WORD_W-1:0] cand);
            pending_verdicts.push_back(predict_verdict(sq, cand));
        endfunction

        function void check_verdict(logic acc, logic [BITS_W-1:0] bits,
                                    logic [WORD_W-1:0] mask);
            verdict_t want;
            if (pending_verdicts.size() == 0)
            begin
                $error("result beat with no item pending");
                mismatch_count++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (acc !== want.accepted)
            begin
                $error("accepted: expected %0d, got %0d", want.accepted, acc);
                mismatch_count++;
            end
            if (bits !== want.index_bits)
            begin
                $error("index_bits: expected %0d, got %0d", want.index_bits, bits);
                mismatch_count++;
            end
            if (mask !== want.relevant_mask)
            begin
                $error("relevant_mask: expected %h, got %h", want.relevant_mask, mask);
                mismatch_count++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   idle_mode = 0;

    magic_verdict_book book;

    // known perfect multipliers for squares 0..9
    logic [WORD_W-1:0] rook_magics [MAGIC_COUNT] = '{
        64'h0080001020400080, 64'h0040001000200040, 64'h0080081000200080,
        64'h0080040800100080, 64'h0080020400080080, 64'h0080010200040080,
        64'h0080008001000200, 64'h0080002040800100, 64'h0000800020400080,
        64'h0000400020005000
    };

    rmcc_item_if   item_ch();
    rmcc_result_if result_ch();

    rook_magic_collision_check dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    always #2 clk = ~clk;

    task automatic offer_candidate(input logic [SQ_W-1:0] sq, input logic [WORD_W-1:0] cand);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 19 : (idle_mode == 1) ? 53 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.square    <= sq;
        item_ch.candidate <= cand;
        do
            @(posedge clk);
        while (!item_ch.ready);
        book.note_candidate(sq, cand);
    endtask

    initial
    begin
        logic [SQ_W-1:0]   sq;
        logic [WORD_W-1:0] cand;
        int                pick;
        int                slot;
        book = new();
        item_ch.valid     <= 1'b0;
        item_ch.square    <= '0;
        item_ch.candidate <= '0;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < MAGIC_COUNT; i++)
            offer_candidate(SQ_W'(i), rook_magics[i]);
        offer_candidate(6'd0, '0);                    // zero multiplier
        offer_candidate(6'd63, '1);
        offer_candidate(6'd7, 64'h8000000000000000);
        offer_candidate(6'd56, 64'd1);                // subsets on the A file all give index zero
        offer_candidate(6'd27, '1);                   // interior, 10-bit mask
        offer_candidate(6'd36, '0);
        offer_candidate(6'd1, rook_magics[1] ^ (64'd1 << 54));
        offer_candidate(6'd9, ~rook_magics[9]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_mode = (i * 3) / RANDOM_ITEMS;
            pick = $urandom_range(99);
            slot = $urandom_range(MAGIC_COUNT - 1);
            sq = SQ_W'($urandom);
            cand = {$urandom, $urandom};
            if (pick < 30)
            begin
                // known magics (full-length walks), some with one bit flipped
                sq = SQ_W'(slot);
                cand = rook_magics[slot];
                if (pick < 12)
                    cand = cand ^ (64'd1 << $urandom_range(WORD_W - 1));
            end
            else if (pick < 55)
                cand = cand & {$urandom, $urandom} & {$urandom, $urandom};
            else if (pick < 65)
                cand = cand >> $urandom_range(WORD_W - 1);
            else if (pick < 68)
                cand = '0;
            offer_candidate(sq, cand);
        end
        item_ch.valid <= 1'b0;

        while (book.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (book.mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result side: check each beat, stall at random, one long hold-off in the last phase
    initial
    begin
        int hold_left;
        bit held;
        int stall_pct;
        hold_left = 0;
        held = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                book.check_verdict(result_ch.accepted, result_ch.index_bits,
                                   result_ch.relevant_mask);
            if (idle_mode == 2 && !held)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            stall_pct = (idle_mode == 0) ? 53 : (idle_mode == 1) ? 19 : 0;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
